// ----- hw/rtl/xbr_pkg.sv -----
// Shared types, constants and CRC function for the XMODEM block receiver.
`timescale 1ns / 1ps

package xbr_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int ADDR_W      = 3;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    localparam logic REG_CHECKSUM_MODE = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam logic        CHECKSUM_MODE_RST = 1'b1;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd12000;

    typedef struct packed {
        logic        checksum_mode;
        logic [15:0] timeout_ticks;
    } xbr_cfg_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       block_end;
        logic       block_good;
        logic [1:0] status;
    } xbr_result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/xmodem_block_receiver_core.sv -----
// Top level of the XMODEM block receiver: input stage, engine, result register.
//
// Input channel (in_valid/in_stall) carries one word per line byte or retry
// tick: mode 0 = rx_byte from the line, mode 1 = handshake tick.
// Output channel (out_valid/out_stall) returns exactly one result word per
// input word: control byte to send (tx_valid/tx_byte), payload byte
// (data_valid/data_byte), block verdict (block_end/block_good) and status.
// Each word passes through the input register, then the result register, before
// out_valid. Throughput is one word per cycle while out_stall is low; the
// protocol engine computes the result combinationally between the two
// registers and updates its state as the result register loads.
// Registers (APB, pready always high): 0x0 checksum_mode, 0x4 timeout_ticks.
// Write them only while no word is in flight.
// Reset clears both stages and returns the engine to waiting for SOH with
// the tick count at zero; registers return to CRC mode, 12000 ticks.
// While out_stall is high the result word holds; the input register still
// takes one more word, then in_stall rises until the result is taken.
`timescale 1ns / 1ps

module xmodem_block_receiver_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xbr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       tx_valid,
    output logic [7:0]                 tx_byte,
    output logic                       data_valid,
    output logic [7:0]                 data_byte,
    output logic                       block_end,
    output logic                       block_good,
    output logic [1:0]                 status
);
    import xbr_pkg::*;

    xbr_cfg_t    cfg;
    xbr_result_t res;
    xbr_result_t res_reg;

    logic       s1_valid_reg;
    logic       s1_mode_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       load_s1;

    xbr_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign load_s1  = in_valid && !in_stall;

    xbr_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .tick    (s1_mode_reg),
        .rx_byte (s1_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_valid   = res_reg.tx_valid;
    assign tx_byte    = res_reg.tx_byte;
    assign data_valid = res_reg.data_valid;
    assign data_byte  = res_reg.data_byte;
    assign block_end  = res_reg.block_end;
    assign block_good = res_reg.block_good;
    assign status     = res_reg.status;

endmodule

// ----- hw/rtl/xbr_cfg_regs.sv -----
// APB configuration registers: checksum mode and handshake timeout.
`timescale 1ns / 1ps

module xbr_cfg_regs
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [xbr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output xbr_pkg::xbr_cfg_t     cfg
);
    import xbr_pkg::*;

    logic        mode_reg;
    logic [15:0] ticks_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= CHECKSUM_MODE_RST;
            ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_CHECKSUM_MODE: mode_reg  <= pwdata[0];
                REG_TIMEOUT_TICKS: ticks_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CHECKSUM_MODE: prdata = {31'd0, mode_reg};
            REG_TIMEOUT_TICKS: prdata = {16'd0, ticks_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.checksum_mode = mode_reg;
    assign cfg.timeout_ticks = ticks_reg;

endmodule

// ----- hw/rtl/xbr_engine.sv -----
// Protocol state and per-word result logic of the XMODEM receiver.
`timescale 1ns / 1ps

module xbr_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 tick,
    input  logic [7:0]           rx_byte,
    input  xbr_pkg::xbr_cfg_t    cfg,
    output xbr_pkg::xbr_result_t res
);
    import xbr_pkg::*;

    typedef enum logic [3:0] {
        PH_WAIT, PH_NUM1, PH_NUM2, PH_DATA, PH_CHK1,
        PH_CHK2, PH_NEXT, PH_DONE, PH_TIMEOUT, PH_ERROR
    } phase_t;

    phase_t            phase_reg,  phase_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [7:0]        sum_reg,    sum_next;
    logic [15:0]       crc_reg,    crc_next;
    logic [7:0]        hi_reg,     hi_next;
    logic [15:0]       ticks_reg,  ticks_next;
    logic              good;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        crc_next   = crc_reg;
        hi_next    = hi_reg;
        ticks_next = ticks_reg;
        good       = 1'b0;
        res        = '0;

        if (phase_reg == PH_DONE)
        begin
            res.status = ST_DONE;
        end
        else if (phase_reg == PH_TIMEOUT)
        begin
            res.status = ST_TIMEOUT;
        end
        else if (phase_reg == PH_ERROR)
        begin
            res.status = ST_ERROR;
        end
        else if (tick)
        begin
            if (phase_reg == PH_WAIT)
            begin
                if (ticks_reg != 16'hFFFF)
                begin
                    ticks_next = ticks_reg + 16'd1;
                end
                if (ticks_next >= cfg.timeout_ticks)
                begin
                    phase_next = PH_TIMEOUT;
                    res.status = ST_TIMEOUT;
                end
                else
                begin
                    res.tx_valid = 1'b1;
                    res.tx_byte  = cfg.checksum_mode ? CH_C : CH_NAK;
                end
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_WAIT, PH_NEXT:
                begin
                    if (rx_byte == CH_SOH)
                    begin
                        phase_next = PH_NUM1;
                        idx_next   = '0;
                        sum_next   = '0;
                        crc_next   = '0;
                        hi_next    = '0;
                    end
                    else if (phase_reg == PH_NEXT)
                    begin
                        if (rx_byte == CH_EOT)
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = CH_ACK;
                            phase_next   = PH_DONE;
                            res.status   = ST_DONE;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            res.status = ST_ERROR;
                        end
                    end
                end
                PH_NUM1: phase_next = PH_NUM2;
                PH_NUM2: phase_next = PH_DATA;
                PH_DATA:
                begin
                    res.data_valid = 1'b1;
                    res.data_byte  = rx_byte;
                    sum_next       = sum_reg + rx_byte;
                    crc_next       = crc_byte(crc_reg, rx_byte);
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(BLOCK_BYTES - 1))
                    begin
                        phase_next = PH_CHK1;
                    end
                end
                PH_CHK1:
                begin
                    if (cfg.checksum_mode)
                    begin
                        hi_next    = rx_byte;
                        phase_next = PH_CHK2;
                    end
                    else
                    begin
                        good           = (rx_byte == sum_reg);
                        res.block_end  = 1'b1;
                        res.block_good = good;
                        res.tx_valid   = 1'b1;
                        res.tx_byte    = good ? CH_ACK : CH_NAK;
                        phase_next     = PH_NEXT;
                    end
                end
                PH_CHK2:
                begin
                    good           = ({hi_reg, rx_byte} == crc_reg);
                    res.block_end  = 1'b1;
                    res.block_good = good;
                    res.tx_valid   = 1'b1;
                    res.tx_byte    = good ? CH_ACK : CH_NAK;
                    phase_next     = PH_NEXT;
                end
                default:
                begin
                    phase_next = PH_ERROR;
                    res.status = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            idx_reg   <= '0;
            sum_reg   <= '0;
            crc_reg   <= '0;
            hi_reg    <= '0;
            ticks_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            crc_reg   <= crc_next;
            hi_reg    <= hi_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the XMODEM block receiver core: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;

    import xbr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    typedef enum logic [3:0] {
        P_IDLE, P_BLKNUM, P_BLKNUM_INV, P_PAYLOAD, P_CHK_HI, P_CHK_LO,
        P_AFTER, P_DONE, P_TIMEDOUT, P_FAILED
    } rx_phase_t;

    typedef enum int {SW_NONE, SW_BEFORE_CHECK, SW_BETWEEN_CRC} mode_switch_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              mode;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic              block_end;
    logic              block_good;
    logic [1:0]        status;

    // receiver model state and register copies
    rx_phase_t   ph;
    int          pay_idx;
    logic [7:0]  acc_sum;
    logic [15:0] acc_crc;
    logic [7:0]  crc_hi;
    logic [15:0] ticks;
    logic        cfg_crc;
    logic [15:0] cfg_timeout;

    xbr_result_t result_q[$];
    int          mismatches;
    int          cycles;
    int          data_words;
    int          blocks_sent;
    bit          calm;
    bit          hold_req;

    xmodem_block_receiver_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .block_end  (block_end),
        .block_good (block_good),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[xmodem_block_receiver_core] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        int   i;
        for (i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic xbr_result_t xfer_predict(input logic m, input logic [7:0] b);
        xbr_result_t r;
        r = '0;
        case (ph)
            P_DONE:     r.status = ST_DONE;
            P_TIMEDOUT: r.status = ST_TIMEOUT;
            P_FAILED:   r.status = ST_ERROR;
            default:
            begin
                if (m)
                begin
                    if (ph == P_IDLE)
                    begin
                        if (ticks != 16'hFFFF)
                        begin
                            ticks = ticks + 16'd1;
                        end
                        if (ticks >= cfg_timeout)
                        begin
                            ph       = P_TIMEDOUT;
                            r.status = ST_TIMEOUT;
                        end
                        else
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = cfg_crc ? CH_C : CH_NAK;
                        end
                    end
                end
                else
                begin
                    case (ph) inside
                        P_IDLE, P_AFTER:
                        begin
                            if (b == CH_SOH)
                            begin
                                ph      = P_BLKNUM;
                                pay_idx = 0;
                                acc_sum = '0;
                                acc_crc = '0;
                                crc_hi  = '0;
                            end
                            else if (ph == P_AFTER && b == CH_EOT)
                            begin
                                ph         = P_DONE;
                                r.tx_valid = 1'b1;
                                r.tx_byte  = CH_ACK;
                                r.status   = ST_DONE;
                            end
                            else if (ph == P_AFTER)
                            begin
                                ph       = P_FAILED;
                                r.status = ST_ERROR;
                            end
                        end
                        P_BLKNUM:     ph = P_BLKNUM_INV;
                        P_BLKNUM_INV: ph = P_PAYLOAD;
                        P_PAYLOAD:
                        begin
                            r.data_valid = 1'b1;
                            r.data_byte  = b;
                            acc_sum      = acc_sum + b;
                            acc_crc      = crc16_step(acc_crc, b);
                            if (pay_idx == BLOCK_BYTES - 1)
                            begin
                                pay_idx = 0;
                                ph      = P_CHK_HI;
                            end
                            else
                            begin
                                pay_idx++;
                            end
                        end
                        P_CHK_HI:
                        begin
                            if (cfg_crc)
                            begin
                                crc_hi = b;
                                ph     = P_CHK_LO;
                            end
                            else
                            begin
                                r.block_end  = 1'b1;
                                r.block_good = (b == acc_sum);
                                r.tx_valid   = 1'b1;
                                r.tx_byte    = r.block_good ? CH_ACK : CH_NAK;
                                ph           = P_AFTER;
                            end
                        end
                        P_CHK_LO:
                        begin
                            r.block_end  = 1'b1;
                            r.block_good = ({crc_hi, b} == acc_crc);
                            r.tx_valid   = 1'b1;
                            r.tx_byte    = r.block_good ? CH_ACK : CH_NAK;
                            ph           = P_AFTER;
                        end
                        default:
                        begin
                            ph       = P_FAILED;
                            r.status = ST_ERROR;
                        end
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic enqueue_expected(input xbr_result_t r);
        result_q.insert(result_q.size(), r);
    endtask

    always @(posedge clk)
    begin
        xbr_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("result word with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = result_q.pop_front();
                check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
                check_field("tx_byte", want.tx_byte, tx_byte);
                check_field("data_valid", 8'(want.data_valid), 8'(data_valid));
                check_field("data_byte", want.data_byte, data_byte);
                check_field("block_end", 8'(want.block_end), 8'(block_end));
                check_field("block_good", 8'(want.block_good), 8'(block_good));
                check_field("status", 8'(want.status), 8'(status));
            end
        end
    end

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
        begin
            return 0;
        end
        else if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // output side backpressure; a hold request forces one long stall
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                n = pick_pause();
                if (n == 0)
                begin
                    out_stall <= 1'b0;
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic send_word(input logic m, input logic [7:0] b);
        int gap;
        gap = pick_pause();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        enqueue_expected(xfer_predict(m, b));
        if (!m)
        begin
            data_words++;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        wait_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_CHECKSUM_MODE)
        begin
            cfg_crc = value[0];
        end
        else
        begin
            cfg_timeout = value[15:0];
        end
    endtask

    task automatic read_reg(input logic idx, output logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic stray_tick();
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            send_word(1'b1, 8'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_payload();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            return 8'h00;
        end
        else if (r == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    task automatic send_block(input mode_switch_t sw, input bit corrupt);
        logic [7:0]  blk;
        logic [7:0]  d;
        logic [7:0]  sum_v;
        logic [15:0] crc_v;
        logic [15:0] chk;
        int          i;
        blk   = 8'($urandom);
        sum_v = '0;
        crc_v = '0;
        send_word(1'b0, CH_SOH);
        stray_tick();
        send_word(1'b0, blk);
        stray_tick();
        send_word(1'b0, ~blk);
        for (i = 0; i < BLOCK_BYTES; i++)
        begin
            stray_tick();
            d     = pick_payload();
            sum_v = sum_v + d;
            crc_v = crc16_step(crc_v, d);
            send_word(1'b0, d);
        end
        if (sw == SW_BEFORE_CHECK)
        begin
            write_reg(REG_CHECKSUM_MODE, {31'd0, ~cfg_crc});
        end
        stray_tick();
        if (cfg_crc)
        begin
            chk = corrupt ? crc_v ^ 16'($urandom_range(1, 65535)) : crc_v;
            send_word(1'b0, chk[15:8]);
            // low byte still judged as CRC after the mode flips
            if (sw == SW_BETWEEN_CRC)
            begin
                write_reg(REG_CHECKSUM_MODE, 32'd0);
            end
            stray_tick();
            send_word(1'b0, chk[7:0]);
        end
        else
        begin
            sum_v = corrupt ? sum_v ^ 8'($urandom_range(1, 255)) : sum_v;
            send_word(1'b0, sum_v);
        end
    endtask

    task automatic test_register_reset();
        logic [31:0] v;
        read_reg(REG_CHECKSUM_MODE, v);
        if (v[0] !== CHECKSUM_MODE_RST)
        begin
            $error("checksum_mode: expected %0h, got %0h", CHECKSUM_MODE_RST, v[0]);
            mismatches++;
        end
        read_reg(REG_TIMEOUT_TICKS, v);
        if (v[15:0] !== TIMEOUT_TICKS_RST)
        begin
            $error("timeout_ticks: expected %0h, got %0h", TIMEOUT_TICKS_RST, v[15:0]);
            mismatches++;
        end
    endtask

    task automatic test_handshake();
        write_reg(REG_TIMEOUT_TICKS, 32'd65535);
        write_reg(REG_CHECKSUM_MODE, 32'd0);
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, CH_EOT);
        send_word(1'b0, CH_ACK);
        send_word(1'b1, CH_SOH);
        write_reg(REG_CHECKSUM_MODE, 32'd1);
        write_reg(REG_TIMEOUT_TICKS, 32'd20);
        send_word(1'b1, 8'($urandom));
        send_word(1'b0, 8'($urandom_range(2, 255)));
        send_word(1'b1, 8'($urandom));
        send_word(1'b1, 8'($urandom));
    endtask

    task automatic test_random_blocks(input int target);
        int           k;
        int           r;
        logic         crc_sel;
        mode_switch_t sw;
        bit           corrupt;
        while (data_words < target)
        begin
            k    = blocks_sent;
            calm = ($urandom_range(0, 4) == 0);
            crc_sel = (k == 0) ? 1'b0 : (k == 1) ? 1'b1 : (k == 2) ? 1'b0 :
                      1'($urandom_range(0, 1));
            if (k < 3 || $urandom_range(0, 1) == 1)
            begin
                write_reg(REG_CHECKSUM_MODE, {31'd0, crc_sel});
            end
            // tick limit only matters before the first block; extremes go in afterward
            if (k == 1)
            begin
                write_reg(REG_TIMEOUT_TICKS, 32'd1);
            end
            else if (k == 2)
            begin
                write_reg(REG_TIMEOUT_TICKS, 32'd65535);
            end
            else if (k > 2 && $urandom_range(0, 2) == 0)
            begin
                write_reg(REG_TIMEOUT_TICKS, $urandom_range(1, 65535));
            end
            r  = $urandom_range(0, 5);
            sw = (k == 1) ? SW_BETWEEN_CRC : (k == 2) ? SW_BEFORE_CHECK :
                 (r == 0) ? SW_BEFORE_CHECK : (r == 1) ? SW_BETWEEN_CRC : SW_NONE;
            corrupt = (k == 1) || (k != 0 && $urandom_range(0, 3) == 0);
            send_block(sw, corrupt);
            blocks_sent++;
        end
        calm = 1'b0;
    endtask

    task automatic test_output_hold();
        int i;
        wait_drained();
        calm     = 1'b1;
        hold_req = 1'b1;
        for (i = 0; i < 24; i++)
        begin
            send_word(1'b1, 8'($urandom));
        end
        wait_drained();
        calm = 1'b0;
    endtask

    task automatic test_end_of_transfer();
        logic [7:0] b;
        int         i;
        if ($urandom_range(0, 1) == 1)
        begin
            b = CH_EOT;
        end
        else
        begin
            do
            begin
                b = 8'($urandom);
            end
            while (b == CH_SOH || b == CH_EOT);
        end
        send_word(1'b0, b);
        for (i = 0; i < 8; i++)
        begin
            send_word(1'($urandom_range(0, 1)), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        mode        = 1'b0;
        rx_byte     = '0;
        ph          = P_IDLE;
        pay_idx     = 0;
        acc_sum     = '0;
        acc_crc     = '0;
        crc_hi      = '0;
        ticks       = '0;
        cfg_crc     = CHECKSUM_MODE_RST;
        cfg_timeout = TIMEOUT_TICKS_RST;
        mismatches  = 0;
        cycles      = 0;
        data_words  = 0;
        blocks_sent = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_reset();
        test_handshake();
        test_random_blocks(300);
        test_output_hold();
        test_random_blocks(600);
        test_end_of_transfer();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && result_q.size() == 0)
        begin
            $display("[xmodem_block_receiver_core] OK");
        end
        else
        begin
            $display("[xmodem_block_receiver_core] ERROR");
        end
        $finish;
    end

endmodule
